[design/tsb_pkg.sv]
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types, constants and helpers for the terrain splat blend pipeline.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int CAS_STG = 8;
  localparam int BLD_STG = 2;
  localparam int SHD_STG = 2;
  localparam int NSTG    = CAS_STG + BLD_STG + SHD_STG;

  localparam int WL      = 17;
  localparam int NLAYER  = 5;
  localparam int NCHAN   = 3;

  localparam logic [WL-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [7:0]    CHAN_MAX   = 8'hFF;
  // ceil(2^32 / 255); exact floor(x/255) for x < 2^24
  localparam logic [24:0]   RECIP_255  = 25'd16843010;

  typedef struct packed {
    logic [23:0] base_rgb;
    logic [23:0] layer1_rgb;
    logic [23:0] layer2_rgb;
    logic [23:0] layer3_rgb;
    logic [23:0] layer4_rgb;
    logic [31:0] blend_alphas;
    logic [23:0] shadow_rgb;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_t;

  typedef struct packed {
    in_t                  pix;
    logic [WL-1:0]        left;
    logic [23:0]          prod;
    logic [3:0][WL-1:0]   w;
  } cas_t;

  typedef struct packed {
    logic [NCHAN-1:0][7:0] v;
    logic [23:0]           shadow;
  } blend_t;

  function automatic logic [WL-1:0] div255(input logic [23:0] x);
    logic [48:0] p;
    p = 49'(x) * 49'(RECIP_255);
    return WL'(p >> 32);
  endfunction

endpackage

[design/tsb_flow.sv]
// ----------------------------------------------------------------------------
// tsb_flow
// Valid tracking and per-stage load enables; a stage loads when it is empty
// or when the stage after it moves on.
// ----------------------------------------------------------------------------
module tsb_flow (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     out_stall,
  output logic [tsb_pkg::NSTG-1:0] en,
  output logic                     out_valid
);

  logic [tsb_pkg::NSTG-1:0] v_r;
  logic [tsb_pkg::NSTG-1:0] v_nxt;

  assign en[tsb_pkg::NSTG-1] = !v_r[tsb_pkg::NSTG-1] || !out_stall;

  genvar g;
  generate
    for (g = 0; g < tsb_pkg::NSTG - 1; g++) begin : g_en
      assign en[g] = !v_r[g] || en[g+1];
    end
  endgenerate

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < tsb_pkg::NSTG; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign out_valid = v_r[tsb_pkg::NSTG-1];

endmodule

[design/tsb_cascade.sv]
// ----------------------------------------------------------------------------
// tsb_cascade
// Layer weight cascade, top layer first: per layer one stage forms
// left*alpha, the next divides by 255 and takes the weight off what is left.
// ----------------------------------------------------------------------------
module tsb_cascade (
  input  logic                        clk,
  input  tsb_pkg::in_t                pix_i,
  input  logic [tsb_pkg::CAS_STG-1:0] en,
  output tsb_pkg::cas_t               cas_o
);

  tsb_pkg::cas_t st_r   [tsb_pkg::CAS_STG];
  tsb_pkg::cas_t st_nxt [tsb_pkg::CAS_STG];

  always_comb begin
    tsb_pkg::cas_t src;
    int            j;
    logic [7:0]    a;
    for (int k = 0; k < tsb_pkg::CAS_STG; k++) begin
      if (k == 0) begin
        src.pix  = pix_i;
        src.left = tsb_pkg::WEIGHT_ONE;
        src.prod = '0;
        src.w    = '0;
      end else begin
        src = st_r[(k == 0) ? 0 : k - 1];
      end
      j = 3 - (k >> 1);
      a = src.pix.blend_alphas[8*j +: 8];
      st_nxt[k] = src;
      if ((k & 1) == 0) begin
        st_nxt[k].prod = 24'({7'b0, src.left} * {16'b0, a});
      end else begin
        st_nxt[k].w[j] = tsb_pkg::div255(src.prod);
        st_nxt[k].left = src.left - tsb_pkg::div255(src.prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tsb_pkg::CAS_STG; k++) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign cas_o = st_r[tsb_pkg::CAS_STG-1];

endmodule

[design/tsb_blend.sv]
// ----------------------------------------------------------------------------
// tsb_blend
// Weighted color sum: one stage of color*weight products, one stage of
// per-channel sums truncated to a byte.
// ----------------------------------------------------------------------------
module tsb_blend (
  input  logic                        clk,
  input  tsb_pkg::cas_t               cas_i,
  input  logic [tsb_pkg::BLD_STG-1:0] en,
  output tsb_pkg::blend_t             blend_o
);

  logic [tsb_pkg::NCHAN-1:0][tsb_pkg::NLAYER-1:0][23:0] prod_r;
  logic [tsb_pkg::NCHAN-1:0][tsb_pkg::NLAYER-1:0][23:0] prod_nxt;
  logic [23:0]                                          shadow_r;
  tsb_pkg::blend_t                                      blend_r;
  tsb_pkg::blend_t                                      blend_nxt;

  logic [tsb_pkg::NLAYER-1:0][23:0]         rgb;
  logic [tsb_pkg::NLAYER-1:0][tsb_pkg::WL-1:0] wt;

  always_comb begin
    rgb[0] = cas_i.pix.base_rgb;
    rgb[1] = cas_i.pix.layer1_rgb;
    rgb[2] = cas_i.pix.layer2_rgb;
    rgb[3] = cas_i.pix.layer3_rgb;
    rgb[4] = cas_i.pix.layer4_rgb;
    wt[0]  = cas_i.left;
    for (int l = 1; l < tsb_pkg::NLAYER; l++) begin
      wt[l] = cas_i.w[l-1];
    end
    for (int c = 0; c < tsb_pkg::NCHAN; c++) begin
      for (int l = 0; l < tsb_pkg::NLAYER; l++) begin
        prod_nxt[c][l] = 24'({16'b0, rgb[l][8*c +: 8]} * {7'b0, wt[l]});
      end
    end
  end

  always_comb begin
    logic [23:0] acc;
    blend_nxt.shadow = shadow_r;
    for (int c = 0; c < tsb_pkg::NCHAN; c++) begin
      acc = '0;
      for (int l = 0; l < tsb_pkg::NLAYER; l++) begin
        acc = acc + prod_r[c][l];
      end
      blend_nxt.v[c] = acc[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r   <= prod_nxt;
      shadow_r <= cas_i.pix.shadow_rgb;
    end
    if (en[1]) begin
      blend_r <= blend_nxt;
    end
  end

  assign blend_o = blend_r;

endmodule

[design/tsb_shade.sv]
// ----------------------------------------------------------------------------
// tsb_shade
// Shadow/light modulation: v*s*2 in one stage, divide by 255 and saturate
// in the next.
// ----------------------------------------------------------------------------
module tsb_shade (
  input  logic                        clk,
  input  tsb_pkg::blend_t             blend_i,
  input  logic [tsb_pkg::SHD_STG-1:0] en,
  output tsb_pkg::out_t               out_o
);

  logic [tsb_pkg::NCHAN-1:0][16:0] m_r;
  logic [tsb_pkg::NCHAN-1:0][16:0] m_nxt;
  logic [tsb_pkg::NCHAN-1:0][7:0]  q;
  tsb_pkg::out_t                   out_r;
  tsb_pkg::out_t                   out_nxt;

  always_comb begin
    logic [15:0]         vs;
    logic [tsb_pkg::WL-1:0] d;
    for (int c = 0; c < tsb_pkg::NCHAN; c++) begin
      vs       = 16'({8'b0, blend_i.v[c]} * {8'b0, blend_i.shadow[8*c +: 8]});
      m_nxt[c] = {vs, 1'b0};
    end
    for (int c = 0; c < tsb_pkg::NCHAN; c++) begin
      d    = tsb_pkg::div255({7'b0, m_r[c]});
      q[c] = (d > tsb_pkg::WL'(tsb_pkg::CHAN_MAX)) ? tsb_pkg::CHAN_MAX : d[7:0];
    end
    out_nxt.out_red   = q[0];
    out_nxt.out_green = q[1];
    out_nxt.out_blue  = q[2];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r <= m_nxt;
    end
    if (en[1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_o = out_r;

endmodule

[design/terrain_splat_blend_shadow_modulate.sv]
// ----------------------------------------------------------------------------
// terrain_splat_blend_shadow_modulate
// Five-layer terrain splat blend with cascaded weights and shadow modulation.
//
//   channel  ports                        transaction
//   input    in_valid / in_stall / in_data    one pixel (five colors, alphas,
//                                             shadow)
//   output   out_valid / out_stall / out_data one modulated RGB pixel
//
// One pixel per clock sustained while out_stall is low; the pixel passes the
// four-layer weight cascade (multiply, then divide-by-255 by reciprocal, per layer).
// Each stage loads when empty or when its successor moves, so bubbles fill
// while the output is stalled. Synchronous active-low reset clears valids.
// ----------------------------------------------------------------------------
module terrain_splat_blend_shadow_modulate (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tsb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tsb_pkg::out_t out_data
);

  logic [tsb_pkg::NSTG-1:0] en;
  tsb_pkg::cas_t            cas;
  tsb_pkg::blend_t          blend;

  tsb_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .en        (en),
    .out_valid (out_valid)
  );

  assign in_stall = !en[0];

  tsb_cascade u_cascade (
    .clk   (clk),
    .pix_i (in_data),
    .en    (en[tsb_pkg::CAS_STG-1:0]),
    .cas_o (cas)
  );

  tsb_blend u_blend (
    .clk     (clk),
    .cas_i   (cas),
    .en      (en[tsb_pkg::CAS_STG+tsb_pkg::BLD_STG-1:tsb_pkg::CAS_STG]),
    .blend_o (blend)
  );

  tsb_shade u_shade (
    .clk     (clk),
    .blend_i (blend),
    .en      (en[tsb_pkg::NSTG-1:tsb_pkg::CAS_STG+tsb_pkg::BLD_STG]),
    .out_o   (out_data)
  );

endmodule

[design/tsb_checker.sv]
// ----------------------------------------------------------------------------
// tsb_checker
// Port-level checks for the terrain splat blend pipeline.
// ----------------------------------------------------------------------------
module tsb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input tsb_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input tsb_pkg::out_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a free output drains every stage, so the input must be open
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // input only stalls when the pipeline is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind terrain_splat_blend_shadow_modulate tsb_checker u_tsb_checker (.*);

[sim/terrain_splat_blend_shadow_modulate_tb.sv]
// ----------------------------------------------------------------------------
// terrain_splat_blend_shadow_modulate_tb
// Self-checking bench for the splat blend pipeline. Directed pixels cover
// zero and full opacities, single-layer selection, black and double-bright
// shadow, and saturation; then a long random stream runs with random gaps
// and output stalls. Every output pixel is compared per channel against a
// behavioral blend/modulate computation.
// ----------------------------------------------------------------------------
module terrain_splat_blend_shadow_modulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1550;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_WAIT      = 18;
  localparam int MAX_PRINTED   = 30;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  tsb_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall;
  tsb_pkg::out_t  out_data;

  tsb_pkg::out_t  expected_pixels[$];
  tsb_pkg::out_t  head_pixel;
  int    error_count;
  int    pixels_sent;
  int    pixels_checked;
  int    stall_cnt;
  int    cycle_count;
  bit    burst_mode;

  terrain_splat_blend_shadow_modulate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cascaded weights, weighted sum, then shadow scale with saturation.
  function automatic tsb_pkg::out_t blend_pixel(input tsb_pkg::in_t px);
    logic [23:0] colors [5];
    int unsigned w [5];
    int unsigned chan [3];
    int unsigned left;
    int unsigned acc;
    int unsigned v;
    int unsigned s;
    int unsigned m;
    int          l;
    int          c;
    tsb_pkg::out_t r;
    colors[0] = px.base_rgb;
    colors[1] = px.layer1_rgb;
    colors[2] = px.layer2_rgb;
    colors[3] = px.layer3_rgb;
    colors[4] = px.layer4_rgb;
    left = 32'(tsb_pkg::WEIGHT_ONE);
    for (l = 4; l >= 1; l--) begin
      w[l] = (left * 32'(px.blend_alphas[8*(l-1) +: 8])) / 32'(tsb_pkg::CHAN_MAX);
      left = left - w[l];
    end
    w[0] = left;
    for (c = 0; c < 3; c++) begin
      acc = 0;
      for (l = 0; l < 5; l++) begin
        acc = acc + 32'(colors[l][8*c +: 8]) * w[l];
      end
      v = acc >> 16;
      s = 32'(px.shadow_rgb[8*c +: 8]);
      m = (v * s * 2) / 32'(tsb_pkg::CHAN_MAX);
      chan[c] = (m > 32'(tsb_pkg::CHAN_MAX)) ? 32'(tsb_pkg::CHAN_MAX) : m;
    end
    r.out_red   = chan[0][7:0];
    r.out_green = chan[1][7:0];
    r.out_blue  = chan[2][7:0];
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      return 8'h00;
    end else if (pick < 4) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  function automatic tsb_pkg::in_t random_pixel();
    tsb_pkg::in_t px;
    px.base_rgb     = 24'($urandom);
    px.layer1_rgb   = 24'($urandom);
    px.layer2_rgb   = 24'($urandom);
    px.layer3_rgb   = 24'($urandom);
    px.layer4_rgb   = 24'($urandom);
    px.blend_alphas = {random_byte(), random_byte(), random_byte(), random_byte()};
    if ($urandom_range(0, 3) == 0) begin
      px.blend_alphas = 32'($urandom);
    end
    px.shadow_rgb   = {random_byte(), random_byte(), random_byte()};
    if ($urandom_range(0, 3) == 0) begin
      px.shadow_rgb = 24'($urandom);
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    end
    error_count++;
  endtask

  task automatic send_pixel(input tsb_pkg::in_t px);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(blend_pixel(px));
    pixels_sent++;
  endtask

  // Output side: per-result stall length, drawn when a transaction completes.
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      out_stall = 1'b1;
      stall_cnt--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", 0, int'(out_data));
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (out_data.out_red !== head_pixel.out_red)
          report_mismatch("red", int'(head_pixel.out_red), int'(out_data.out_red));
        if (out_data.out_green !== head_pixel.out_green)
          report_mismatch("green", int'(head_pixel.out_green), int'(out_data.out_green));
        if (out_data.out_blue !== head_pixel.out_blue)
          report_mismatch("blue", int'(head_pixel.out_blue), int'(out_data.out_blue));
        pixels_checked++;
      end
      stall_cnt = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_pixels.size());
    $display("simulation failed");
    $finish;
  end

  task automatic test_corners();
    tsb_pkg::in_t px;
    px = '0;
    send_pixel(px);
    px = '1;
    send_pixel(px);
    px = '1;
    px.shadow_rgb = 24'h000000;
    send_pixel(px);
    px = '0;
    px.blend_alphas = 32'hFFFF_FFFF;
    px.shadow_rgb   = 24'hFFFFFF;
    send_pixel(px);
    px = '1;
    px.blend_alphas = 32'h0000_0000;
    px.shadow_rgb   = 24'h80807F;
    send_pixel(px);
  endtask

  task automatic test_base_passthrough();
    tsb_pkg::in_t px;
    for (int i = 0; i < 4; i++) begin
      px = random_pixel();
      px.blend_alphas = 32'h0;
      if (i == 0) px.shadow_rgb = 24'h808080;
      send_pixel(px);
    end
  endtask

  task automatic test_top_layer_full();
    tsb_pkg::in_t px;
    for (int i = 0; i < 4; i++) begin
      px = random_pixel();
      px.blend_alphas[31:24] = 8'hFF;
      send_pixel(px);
    end
  endtask

  task automatic test_single_layers();
    tsb_pkg::in_t px;
    for (int k = 0; k < 4; k++) begin
      px = random_pixel();
      px.blend_alphas = 32'hFF << (8 * k);
      send_pixel(px);
    end
    px = random_pixel();
    px.blend_alphas = 32'h5555_5555;
    px.shadow_rgb   = 24'h555555;
    send_pixel(px);
    px = random_pixel();
    px.blend_alphas = 32'hAAAA_AAAA;
    px.shadow_rgb   = 24'hAAAAAA;
    send_pixel(px);
  endtask

  task automatic test_shadow_saturation();
    tsb_pkg::in_t px;
    for (int i = 0; i < 4; i++) begin
      px = random_pixel();
      px.base_rgb   = 24'hC0_E0_FF;
      px.layer4_rgb = 24'hFF_90_81;
      px.shadow_rgb = (i < 2) ? 24'hFFFFFF : 24'hC0_A0_90;
      send_pixel(px);
    end
  endtask

  task automatic test_random_stream();
    burst_mode = 1'b0;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if ($urandom_range(0, 47) == 0) burst_mode = ~burst_mode;
      send_pixel(random_pixel());
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    stall_cnt      = 0;
    burst_mode     = 1'b0;
    error_count    = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_corners();
    test_base_passthrough();
    test_top_layer_full();
    test_single_layers();
    test_shadow_saturation();
    test_random_stream();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (2 * tsb_pkg::NSTG) @(posedge clk);

    $display("pixels driven: %0d, pixels compared: %0d, channel errors: %0d",
             pixels_sent, pixels_checked, error_count);
    $display("stimulus: opacity and shadow corners, single layers, random stream");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
